[hdl/tdp_pkg.sv]
package tdp_pkg;

   // default operand width of the block
   localparam int DATA_WIDTH_DEFAULT = 32;

   // first trial divisor of the wheel and its step
   localparam int WHEEL_START = 5;
   localparam int WHEEL_STEP  = 6;

   // status of the shared remainder unit
   typedef struct packed {
      logic done;
      logic zero;
   } rem_stat_type;

endpackage

[hdl/tdp_rem.sv]
module tdp_rem #(
   parameter int DATA_WIDTH = tdp_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [DATA_WIDTH-1:0]   dividend,
   input  logic [DATA_WIDTH-1:0]   divisor,
   output tdp_pkg::rem_stat_type   stat
);
   import tdp_pkg::*;

   localparam int CNT_W = $clog2(DATA_WIDTH + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [DATA_WIDTH-1:0] dvd_ff, dvd_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] dvs_ff, dvs_in;
   logic [DATA_WIDTH:0]   shifted;
   logic [DATA_WIDTH:0]   diff;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   assign shifted = {rem_ff, dvd_ff[DATA_WIDTH-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(DATA_WIDTH);
         dvd_in   = dividend;
         dvs_in   = divisor;
         rem_in   = '0;
      end else if (busy_ff) begin
         dvd_in   = {dvd_ff[DATA_WIDTH-2:0], 1'b0};
         rem_in   = diff[DATA_WIDTH] ? shifted[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign stat.done = done_ff;
   assign stat.zero = (rem_ff == '0);

`ifndef SYNTHESIS
   a_no_restart : assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("remainder unit restarted while busy");
   a_last_step_done : assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && count_ff == CNT_W'(1)) |=> (done_ff && !busy_ff))
      else $error("remainder unit missed its completion");
   a_done_idle : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("remainder done while still busy");
`endif

endmodule

[hdl/trial_division_primality_test.sv]
// Primality test by trial division on the 6k +/- 1 wheel.
// Request: present req_candidate (signed, DATA_WIDTH bits) with start high;
// the transfer happens at a rising edge where start is high and busy is low.
// busy stays high while the test runs; no new request is taken meanwhile.
// Response: rsp_strobe is high for exactly one cycle with rsp_is_prime valid;
// every request yields exactly one response and the receiver cannot stall.
// Negative values, zero, one, two, three and even values answer in the cycle
// after the transfer. Other values first take one remainder by three, then
// each divisor pair i, i+2 costs one bound compare plus two remainders.
// All remainders run on a single restoring remainder unit that resolves one
// quotient bit per cycle. A prime near the top of a 32-bit range needs about
// 7700 pairs. The loop bound i*i is kept as a running square updated by
// adds. Reset (synchronous, active high) returns the sequencer to idle and
// drops any test in flight; no response is given for it.
module trial_division_primality_test #(
   parameter int DATA_WIDTH = tdp_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [DATA_WIDTH-1:0] req_candidate,
   output logic                         rsp_strobe,
   output logic                         rsp_is_prime
);
   import tdp_pkg::*;

   localparam int SQ_W = DATA_WIDTH + 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV3,
      ST_CMP,
      ST_DIVA,
      ST_DIVB
   } state_type;

   state_type             state_ff, state_in;
   logic                  strobe_ff, strobe_in;
   logic                  prime_ff, prime_in;
   logic                  go_ff, go_in;
   logic [DATA_WIDTH-1:0] dvs_ff, dvs_in;
   logic [DATA_WIDTH-1:0] n_ff, n_in;
   logic [DATA_WIDTH-1:0] i_ff, i_in;
   logic [SQ_W-1:0]       sq_ff, sq_in;
   logic [DATA_WIDTH-1:0] cand_u;
   logic [SQ_W-1:0]       i_wide;
   rem_stat_type          div_stat;

   assign cand_u = req_candidate;
   assign i_wide = SQ_W'(i_ff);

   // shared remainder unit
   tdp_rem #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (go_ff),
      .dividend (n_ff),
      .divisor  (dvs_ff),
      .stat     (div_stat)
   );

   // sequencer
   always_comb begin
      state_in  = state_ff;
      strobe_in = 1'b0;
      prime_in  = prime_ff;
      go_in     = 1'b0;
      dvs_in    = dvs_ff;
      n_in      = n_ff;
      i_in      = i_ff;
      sq_in     = sq_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               n_in = cand_u;
               if (req_candidate <= 1) begin
                  strobe_in = 1'b1;
                  prime_in  = 1'b0;
               end else if (req_candidate <= 3) begin
                  strobe_in = 1'b1;
                  prime_in  = 1'b1;
               end else if (!cand_u[0]) begin
                  strobe_in = 1'b1;
                  prime_in  = 1'b0;
               end else begin
                  go_in    = 1'b1;
                  dvs_in   = DATA_WIDTH'(3);
                  state_in = ST_DIV3;
               end
            end
         end
         ST_DIV3: begin
            if (div_stat.done) begin
               if (div_stat.zero) begin
                  strobe_in = 1'b1;
                  prime_in  = 1'b0;
                  state_in  = ST_IDLE;
               end else begin
                  i_in     = DATA_WIDTH'(WHEEL_START);
                  sq_in    = SQ_W'(WHEEL_START * WHEEL_START);
                  state_in = ST_CMP;
               end
            end
         end
         ST_CMP: begin
            // loop bound: stop once i squared exceeds the candidate
            if (sq_ff > SQ_W'(n_ff)) begin
               strobe_in = 1'b1;
               prime_in  = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               go_in    = 1'b1;
               dvs_in   = i_ff;
               state_in = ST_DIVA;
            end
         end
         ST_DIVA: begin
            if (div_stat.done) begin
               if (div_stat.zero) begin
                  strobe_in = 1'b1;
                  prime_in  = 1'b0;
                  state_in  = ST_IDLE;
               end else begin
                  go_in    = 1'b1;
                  dvs_in   = i_ff + DATA_WIDTH'(2);
                  state_in = ST_DIVB;
               end
            end
         end
         ST_DIVB: begin
            if (div_stat.done) begin
               if (div_stat.zero) begin
                  strobe_in = 1'b1;
                  prime_in  = 1'b0;
                  state_in  = ST_IDLE;
               end else begin
                  // (i+6)^2 = i^2 + 12i + 36
                  sq_in    = sq_ff + (i_wide << 3) + (i_wide << 2)
                             + SQ_W'(WHEEL_STEP * WHEEL_STEP);
                  i_in     = i_ff + DATA_WIDTH'(WHEEL_STEP);
                  state_in = ST_CMP;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
         go_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         go_ff     <= go_in;
      end
      prime_ff <= prime_in;
      dvs_ff   <= dvs_in;
      n_ff     <= n_in;
      i_ff     <= i_in;
      sq_ff    <= sq_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_strobe   = strobe_ff;
   assign rsp_is_prime = prime_ff;

`ifndef SYNTHESIS
   a_transfer_answered : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted request neither started nor answered");
   a_strobe_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response given while test still running");
   a_done_expected : assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIV3 || state_ff == ST_DIVA
                         || state_ff == ST_DIVB))
      else $error("remainder completed outside a waiting state");
   a_go_from_busy : assert property (@(posedge clock) disable iff (reset)
      go_ff |-> busy)
      else $error("remainder launched while idle");
`endif

endmodule
